// ----- rtl/vu_bar_peak_hold_meter_core_macros.svh -----
// Assertion macros for the bar meter core.
// Checks compile away when SYNTHESIS is defined.
`ifndef VU_BAR_PEAK_HOLD_METER_CORE_MACROS_SVH
`define VU_BAR_PEAK_HOLD_METER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VBPHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("vbphm check failed");
// next-cycle implication
`define VBPHM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("vbphm check failed");
`else
`define VBPHM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VBPHM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/vbphm_pkg.sv -----
// Shared constants, types and codes for the bar meter core.
// No dependencies; imported by every module of the block.
`default_nettype none

package vbphm_pkg;

	localparam int CHANNELS     = 7;
	localparam int SEGMENTS     = 10;
	localparam int LEVEL_FIELDS = 7;

	localparam int LEVEL_W = 8;
	localparam int SEG_W   = $clog2(SEGMENTS + 1);
	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHAN_W  = 3;
	localparam int LIT_W   = 4;
	localparam int MASK_W  = 10;
	localparam int PEAK_W  = 4;
	localparam int ZONE_W  = 2;
	localparam int TOP_W   = 5;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW = 2'd3;

	localparam logic [MS_W-1:0]  HOLD_RST   = 16'd500;
	localparam logic [MS_W-1:0]  DECAY_RST  = 16'd50;
	localparam logic [TOP_W-1:0] GREEN_RST  = 5'd6;
	localparam logic [TOP_W-1:0] YELLOW_RST = 5'd8;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [ZONE_W-1:0] ZONE_GREEN  = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_YELLOW = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_RED    = 2'd2;

	typedef struct packed {
		logic [MS_W-1:0]  hold_ms;
		logic [MS_W-1:0]  decay_ms;
		logic [TOP_W-1:0] green_top;
		logic [TOP_W-1:0] yellow_top;
	} cfg_t;

	typedef struct packed {
		logic [SEG_W-1:0] lit;
		logic [SEG_W-1:0] peak;
	} lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/vbphm_lane.sv -----
// One channel lane: level to segment count, peak hold and decay state.
// Depends on vbphm_pkg and the assertion macro header.
`default_nettype none
`include "vu_bar_peak_hold_meter_core_macros.svh"

module vbphm_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic [vbphm_pkg::LEVEL_W-1:0]         level,
	input  logic [vbphm_pkg::TIME_W-1:0]          now_ms,
	input  vbphm_pkg::cfg_t                       cfg,
	output vbphm_pkg::lane_res_t                  res
);
	import vbphm_pkg::*;

	localparam int PROD_W = LEVEL_W + SEG_W;
	localparam int QSUM_W = PROD_W + 1;

	logic [PROD_W-1:0] prod;
	logic [QSUM_W-1:0] qsum;
	logic [SEG_W-1:0]  lit;
	logic [TIME_W-1:0] elapsed;
	logic [MS_W:0]     thresh;
	logic              decay_due;

	logic [SEG_W-1:0]  peak_q;
	logic [TIME_W-1:0] stamp_q;
	logic [SEG_W-1:0]  lit_s1;

	// x/255 for x < 65535 as (x + (x>>8) + 1) >> 8
	always_comb begin
		prod      = PROD_W'(level) * PROD_W'(SEGMENTS);
		qsum      = QSUM_W'(prod) + QSUM_W'(prod >> LEVEL_W) + QSUM_W'(1);
		lit       = SEG_W'(qsum >> LEVEL_W);
		elapsed   = now_ms - stamp_q;
		thresh    = (MS_W+1)'(cfg.hold_ms) + (MS_W+1)'(cfg.decay_ms);
		decay_due = (elapsed > TIME_W'(thresh)) && (peak_q > lit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			stamp_q <= '0;
		end else if (en) begin
			if (lit > peak_q) begin
				peak_q  <= lit;
				stamp_q <= now_ms;
			end else if (decay_due) begin
				peak_q  <= peak_q - SEG_W'(1);
				stamp_q <= now_ms - TIME_W'(cfg.hold_ms);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lit_s1 <= lit;
		end
	end

	assign res.lit  = lit_s1;
	assign res.peak = peak_q;

	`VBPHM_ASSERT_NXT(a_peak_not_below_bar, clk, arst_n, en, peak_q >= lit_s1)
	`VBPHM_ASSERT_NXT(a_idle_holds, clk, arst_n, !en, $stable(peak_q) && $stable(stamp_q))
	`VBPHM_ASSERT_NXT(a_rise_stamps, clk, arst_n, en && (lit > peak_q), stamp_q == $past(now_ms))

endmodule

`default_nettype wire

// ----- rtl/vbphm_merge.sv -----
// Merge stage: latches all lane results of a frame and sends them out one
// channel per beat with mask, peak flag and colour zone. Depends on vbphm_pkg.
`default_nettype none
`include "vu_bar_peak_hold_meter_core_macros.svh"

module vbphm_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pend,
	input  vbphm_pkg::lane_res_t              lane_res [vbphm_pkg::CHANNELS],
	input  vbphm_pkg::cfg_t                   cfg,
	output logic                              load,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [vbphm_pkg::CHAN_W-1:0]      channel,
	output logic [vbphm_pkg::LIT_W-1:0]       lit_count,
	output logic [vbphm_pkg::MASK_W-1:0]      segment_mask,
	output logic [vbphm_pkg::PEAK_W-1:0]      peak_segments,
	output logic                              peak_shown,
	output logic [vbphm_pkg::ZONE_W-1:0]      peak_zone,
	output logic                              last
);
	import vbphm_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
	localparam int CMP_W = ((SEG_W > TOP_W) ? SEG_W : TOP_W) + 1;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	lane_res_t        res_q [CHANNELS];

	lane_res_t        cur;
	logic             out_fire;
	logic             at_last;
	logic             shown;
	logic [SEG_W-1:0] pm1;

	assign out_fire = busy_q & res_ready;
	assign at_last  = (idx_q == LAST_IDX);
	// take the next frame when empty or as the final channel leaves
	assign load     = pend & (~busy_q | (out_fire & at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int c = 0; c < CHANNELS; c++) begin
				res_q[c] <= lane_res[c];
			end
		end
	end

	always_comb begin
		cur   = res_q[idx_q];
		shown = cur.peak > cur.lit;
		pm1   = cur.peak - SEG_W'(1);
		for (int j = 0; j < MASK_W; j++) begin
			segment_mask[j] = (32'(cur.lit) > j);
		end
		if (!shown) begin
			peak_zone = ZONE_GREEN;
		end else if (CMP_W'(pm1) < CMP_W'(cfg.green_top)) begin
			peak_zone = ZONE_GREEN;
		end else if (CMP_W'(pm1) < CMP_W'(cfg.yellow_top)) begin
			peak_zone = ZONE_YELLOW;
		end else begin
			peak_zone = ZONE_RED;
		end
	end

	assign res_valid     = busy_q;
	assign channel       = CHAN_W'(idx_q);
	assign lit_count     = LIT_W'(cur.lit);
	assign peak_segments = PEAK_W'(cur.peak);
	assign peak_shown    = shown;
	assign last          = at_last;

	`VBPHM_ASSERT_NXT(a_load_starts, clk, arst_n, load, busy_q && (idx_q == '0))
	`VBPHM_ASSERT_NXT(a_last_ends, clk, arst_n, out_fire && at_last && !load, !busy_q)
	`VBPHM_ASSERT_IMP(a_idx_range, clk, arst_n, busy_q, idx_q <= LAST_IDX)

endmodule

`default_nettype wire

// ----- rtl/vu_bar_peak_hold_meter_core.sv -----
// Bar meter core with peak hold. A tick beat gives no result.
// A frame beat runs all channel lanes in the accept cycle; the lane registers and then
// the merge result registers hold it before its first result is valid, then one channel
// result per cycle while res_ready is held high. A new frame is taken while one drains.
// Async reset clears config to defaults, the ms counter and all peaks and stamps.
// Depends on vbphm_pkg, vbphm_lane and vbphm_merge.
`default_nettype none

module vu_bar_peak_hold_meter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vbphm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [vbphm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                cmd,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_0,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_1,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_2,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_3,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_4,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_5,
	input  logic [vbphm_pkg::LEVEL_W-1:0]       level_6,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [vbphm_pkg::CHAN_W-1:0]        channel,
	output logic [vbphm_pkg::LIT_W-1:0]         lit_count,
	output logic [vbphm_pkg::MASK_W-1:0]        segment_mask,
	output logic [vbphm_pkg::PEAK_W-1:0]        peak_segments,
	output logic                                peak_shown,
	output logic [vbphm_pkg::ZONE_W-1:0]        peak_zone,
	output logic                                last
);
	import vbphm_pkg::*;

	cfg_t              cfg_q;
	logic [TIME_W-1:0] now_q;
	logic              pend_q;
	logic              load;
	logic              item_fire;
	logic              frame_fire;

	logic [LEVEL_W-1:0] lvl_fld    [LEVEL_FIELDS];
	logic [LEVEL_W-1:0] lane_level [CHANNELS];
	lane_res_t          lane_res   [CHANNELS];

	assign lvl_fld[0] = level_0;
	assign lvl_fld[1] = level_1;
	assign lvl_fld[2] = level_2;
	assign lvl_fld[3] = level_3;
	assign lvl_fld[4] = level_4;
	assign lvl_fld[5] = level_5;
	assign lvl_fld[6] = level_6;

	assign item_ready = ~pend_q | load;
	assign item_fire  = item_valid & item_ready;
	assign frame_fire = item_fire & (cmd == CMD_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ms    <= HOLD_RST;
			cfg_q.decay_ms   <= DECAY_RST;
			cfg_q.green_top  <= GREEN_RST;
			cfg_q.yellow_top <= YELLOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HOLD:   cfg_q.hold_ms    <= cfg_wdata;
				CFG_DECAY:  cfg_q.decay_ms   <= cfg_wdata;
				CFG_GREEN:  cfg_q.green_top  <= cfg_wdata[TOP_W-1:0];
				CFG_YELLOW: cfg_q.yellow_top <= cfg_wdata[TOP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (item_fire && (cmd == CMD_TICK)) begin
				now_q <= now_q + TIME_W'(1);
			end
			// lane outputs hold a frame until the merge stage copies it
			if (frame_fire) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		if (g < LEVEL_FIELDS) begin : g_fld
			assign lane_level[g] = lvl_fld[g];
		end else begin : g_zero
			assign lane_level[g] = '0;
		end

		vbphm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (frame_fire),
			.level  (lane_level[g]),
			.now_ms (now_q),
			.cfg    (cfg_q),
			.res    (lane_res[g])
		);
	end

	vbphm_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.pend          (pend_q),
		.lane_res      (lane_res),
		.cfg           (cfg_q),
		.load          (load),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.channel       (channel),
		.lit_count     (lit_count),
		.segment_mask  (segment_mask),
		.peak_segments (peak_segments),
		.peak_shown    (peak_shown),
		.peak_zone     (peak_zone),
		.last          (last)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for vu_bar_peak_hold_meter_core: directed and random frame and
// tick beats, checked against an in-bench bar and peak-hold predictor.
// Depends on vbphm_pkg and the meter core RTL only.

module tb_top;

	import vbphm_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int RX_HOLD_LEN = 300;
	localparam int PHASE_BEATS = 48;

	typedef logic [CHANNELS-1:0][LEVEL_W-1:0] levels_t;

	typedef struct {
		logic [CHAN_W-1:0] channel;
		logic [LIT_W-1:0]  lit;
		logic [MASK_W-1:0] mask;
		logic [PEAK_W-1:0] peak;
		logic              shown;
		logic [ZONE_W-1:0] zone;
		logic              last;
	} bar_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = CFG_HOLD;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic                  cmd = CMD_FRAME;
	logic [LEVEL_W-1:0]    level_0 = '0, level_1 = '0, level_2 = '0, level_3 = '0;
	logic [LEVEL_W-1:0]    level_4 = '0, level_5 = '0, level_6 = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic [CHAN_W-1:0]     channel;
	logic [LIT_W-1:0]      lit_count;
	logic [MASK_W-1:0]     segment_mask;
	logic [PEAK_W-1:0]     peak_segments;
	logic                  peak_shown;
	logic [ZONE_W-1:0]     peak_zone;
	logic                  last;

	// predictor state and register mirror
	cfg_t              meter_cfg = '{HOLD_RST, DECAY_RST, GREEN_RST, YELLOW_RST};
	logic [TIME_W-1:0] clock_ms = '0;
	logic [PEAK_W-1:0] held_peak [CHANNELS];
	logic [TIME_W-1:0] held_since [CHANNELS];
	bar_t              bars_due [$];

	int   mismatches = 0;
	int   cycles = 0;
	logic tx_eager = 1'b0;
	logic rx_eager = 1'b0;
	int   rx_hold_cycles = 0;

	vu_bar_peak_hold_meter_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.cmd           (cmd),
		.level_0       (level_0),
		.level_1       (level_1),
		.level_2       (level_2),
		.level_3       (level_3),
		.level_4       (level_4),
		.level_5       (level_5),
		.level_6       (level_6),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.channel       (channel),
		.lit_count     (lit_count),
		.segment_mask  (segment_mask),
		.peak_segments (peak_segments),
		.peak_shown    (peak_shown),
		.peak_zone     (peak_zone),
		.last          (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [ZONE_W-1:0] zone_for(input int seg);
		if (seg < meter_cfg.green_top)
			return ZONE_GREEN;
		if (seg < meter_cfg.yellow_top)
			return ZONE_YELLOW;
		return ZONE_RED;
	endfunction

	// one bar result per channel, peaks and stamps updated in channel order
	function automatic void predict_frame(input levels_t lv);
		bar_t              b;
		int                lit;
		logic [PEAK_W-1:0] pk;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] span;
		span = TIME_W'(meter_cfg.hold_ms) + TIME_W'(meter_cfg.decay_ms);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			lit = (int'(lv[ch]) * SEGMENTS) / 255;
			pk = held_peak[ch];
			if (lit > pk) begin
				pk = PEAK_W'(lit);
				held_since[ch] = clock_ms;
			end else begin
				elapsed = clock_ms - held_since[ch];
				if (elapsed > span && pk > lit) begin
					pk = pk - 1'b1;
					held_since[ch] = clock_ms - TIME_W'(meter_cfg.hold_ms);
				end
			end
			held_peak[ch] = pk;
			b.channel = CHAN_W'(ch);
			b.lit = LIT_W'(lit);
			b.mask = MASK_W'((1 << lit) - 1);
			b.peak = pk;
			b.shown = (pk != 0) && (pk > lit);
			b.zone = b.shown ? zone_for(int'(pk) - 1) : ZONE_GREEN;
			b.last = (ch == CHANNELS - 1);
			bars_due.push_back(b);
		end
	endfunction

	function automatic levels_t random_levels();
		levels_t lv;
		int      loud;
		loud = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			case ($urandom_range(0, 7))
				0: lv[ch] = '0;
				1: lv[ch] = '1;
				default: lv[ch] = LEVEL_W'($urandom_range(0, loud));
			endcase
		end
		return lv;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	task automatic send_beat(input logic beat_cmd, input levels_t lv);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		cmd = beat_cmd;
		{level_6, level_5, level_4, level_3, level_2, level_1, level_0} = lv;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (beat_cmd == CMD_TICK)
			clock_ms = clock_ms + 1'b1;
		else
			predict_frame(lv);
	endtask

	task automatic tick_ms(input int n);
		repeat (n) send_beat(CMD_TICK, random_levels());
	endtask

	// ticks give no result, so wait for every expected bar, then keep idling for one in flight
	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		while (bars_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_HOLD:   meter_cfg.hold_ms = data;
			CFG_DECAY:  meter_cfg.decay_ms = data;
			CFG_GREEN:  meter_cfg.green_top = TOP_W'(data);
			CFG_YELLOW: meter_cfg.yellow_top = TOP_W'(data);
			default: ;
		endcase
	endtask

	task automatic set_config(input int hold, input int decay, input int green, input int yellow);
		settle();
		write_reg(CFG_HOLD, CFG_DATA_W'(hold));
		write_reg(CFG_DECAY, CFG_DATA_W'(decay));
		write_reg(CFG_GREEN, CFG_DATA_W'(green));
		write_reg(CFG_YELLOW, CFG_DATA_W'(yellow));
	endtask

	// receiver: random stall per beat, plus one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				res_ready = 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end
			stall = rx_eager ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				res_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready = 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : bar_check
		bar_t want;
		if (arst_n && res_valid && res_ready) begin
			if (bars_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat for channel %0d with none pending", $time, channel);
			end else begin
				want = bars_due.pop_front();
				compare_field("channel", want.channel, channel);
				compare_field("lit_count", want.lit, lit_count);
				compare_field("segment_mask", want.mask, segment_mask);
				compare_field("peak_segments", want.peak, peak_segments);
				compare_field("peak_shown", want.shown, peak_shown);
				compare_field("peak_zone", want.zone, peak_zone);
				compare_field("last", want.last, last);
			end
		end
	end

	// default registers; segment boundaries either side of some steps
	task automatic test_reset_values();
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		send_beat(CMD_FRAME, {8'd1, 8'd127, 8'd128, 8'd25, 8'd26, 8'd254, 8'd255});
		send_beat(CMD_TICK, {CHANNELS{8'hff}});
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
	endtask

	// peaks frozen by the longest hold, then shown under each zone split
	task automatic test_zone_bounds();
		set_config(65535, 65535, 16, 16);
		send_beat(CMD_FRAME, {8'd102, 8'd128, 8'd153, 8'd179, 8'd204, 8'd230, 8'd255});
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		set_config(65535, 65535, 0, 0);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		set_config(65535, 65535, 3, 8);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		set_config(65535, 65535, 8, 3);     // yellow below green: no yellow zone
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		set_config(65535, 65535, 5, 5);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
	endtask

	task automatic test_peak_decay();
		set_config(0, 0, 6, 8);
		tick_ms(1);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});      // no time passed, no step
		tick_ms(1);
		send_beat(CMD_FRAME, {CHANNELS{8'd230}});    // bar at or over peak: no step
		tick_ms(1);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		// restamp at now - hold sets the pace of later steps
		set_config(2, 1, 6, 8);
		tick_ms(4);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		tick_ms(1);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
		tick_ms(1);
		send_beat(CMD_FRAME, {CHANNELS{8'd0}});
	endtask

	// long receiver hold-off while the sender keeps offering frame and tick beats back to back
	task automatic test_backpressure();
		set_config(4, 2, 6, 8);
		tx_eager = 1'b1;
		rx_hold_cycles = RX_HOLD_LEN;
		repeat (12) begin
			if ($urandom_range(0, 3) == 0)
				send_beat(CMD_TICK, random_levels());
			else
				send_beat(CMD_FRAME, random_levels());
		end
		tx_eager = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_config(3, 2, 6, 8);
				1: set_config(0, 0, 0, 0);
				2: set_config(65535, 65535, 16, 16);
				3: set_config(10, 5, 9, 4);
				4: set_config(0, 7, 3, 8);
				5: set_config(5, 0, 16, 0);
				default: set_config($urandom_range(0, 12), $urandom_range(0, 8),
						$urandom_range(0, 16), $urandom_range(0, 16));
			endcase
			tx_eager = (p % 3 == 1) || (p == 5);
			rx_eager = (p % 3 == 1);
			repeat (PHASE_BEATS) begin
				if ($urandom_range(0, 99) < 45)
					send_beat(CMD_TICK, random_levels());
				else
					send_beat(CMD_FRAME, random_levels());
			end
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	initial begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			held_peak[ch] = '0;
			held_since[ch] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_zone_bounds();
		test_peak_decay();
		test_backpressure();
		test_random_traffic();

		settle();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
